>>> rtl/wsd_pkg.sv
`timescale 1ns / 1ps
package wsd_pkg;

  // Mode codes on the input item
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_TAKE  = 2'd1;
  localparam logic [1:0] MODE_STEAL = 2'd2;
  localparam logic [1:0] MODE_BATCH = 2'd3;

  // Status codes on the result
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int LIMIT_W = 7;   // clamped batch limit, 1..MAX_BATCH
  localparam int OCC_W   = 7;
  localparam int RQ_DEPTH = 4;  // result queue entries
  localparam int RQ_AW    = 2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] task_word;
    logic [4:0]  batch_limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [63:0]      out_word;
    logic             last;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_TAKE,
    CMD_STEAL,
    CMD_BATCH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [63:0]        word;
    logic [LIMIT_W-1:0] limit;
  } cmd_t;

endpackage

>>> rtl/work_stealing_deque_top.sv
`timescale 1ns / 1ps
// Each result is registered with its ring read, then written into the result queue.
// Throughput, while that queue has room: push, take and steal sustain one word per cycle,
// one ring access each; a batch steal enters S_BATCH, then one result per cycle is read.
// Reset (rst, synchronous): deque, command queue and result queue come up empty;
// ring contents are not cleared and only written entries are ever read.
module work_stealing_deque_top #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 64,
  parameter int MAX_BATCH  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  wsd_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output wsd_pkg::out_item_t result
);

  // Front to back command channel
  logic          cmd_valid;
  logic          cmd_ready;
  wsd_pkg::cmd_t cmd;

  // Front: accept words, decode mode, clamp the batch limit, buffer two deep
  wsd_front #(
    .MAX_BATCH (MAX_BATCH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Back: own the ring and its indices, run batch steals, queue the results
  wsd_back #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

>>> rtl/wsd_front.sv
`timescale 1ns / 1ps
module wsd_front #(
  parameter int MAX_BATCH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  wsd_pkg::in_item_t item,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output wsd_pkg::cmd_t    cmd
);

  wsd_pkg::cmd_t                     q [2];
  logic                              head;
  logic [1:0]                        count;
  logic [1:0]                        count_next;
  wsd_pkg::cmd_t                     decoded;
  logic [wsd_pkg::LIMIT_W-1:0]       lim;
  logic                              wr;
  logic                              rd;

  // Classify the word and clamp the batch limit to 1..MAX_BATCH
  always_comb begin
    lim = wsd_pkg::LIMIT_W'(item.batch_limit);
    if (lim == '0) begin
      lim = wsd_pkg::LIMIT_W'(1);
    end
    if (lim > wsd_pkg::LIMIT_W'(MAX_BATCH)) begin
      lim = wsd_pkg::LIMIT_W'(MAX_BATCH);
    end
    case (item.mode)
      wsd_pkg::MODE_PUSH:  decoded.kind = wsd_pkg::CMD_PUSH;
      wsd_pkg::MODE_TAKE:  decoded.kind = wsd_pkg::CMD_TAKE;
      wsd_pkg::MODE_STEAL: decoded.kind = wsd_pkg::CMD_STEAL;
      default:             decoded.kind = wsd_pkg::CMD_BATCH;
    endcase
    decoded.word  = item.task_word;
    decoded.limit = lim;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[head];
  assign wr        = push && !full;
  assign rd        = cmd_valid && cmd_ready;

  always_comb begin
    count_next = count;
    if (wr && !rd) begin
      count_next = count + 2'd1;
    end else if (rd && !wr) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[head ^ count[0]] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      count <= count_next;
      if (rd) begin
        head <= ~head;
      end
    end
  end

endmodule

>>> rtl/wsd_rq.sv
`timescale 1ns / 1ps
module wsd_rq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  wsd_pkg::out_item_t      wr_data,
  output logic [wsd_pkg::RQ_AW:0] count,
  output logic                    empty,
  input  logic                    pop,
  output wsd_pkg::out_item_t      head
);

  wsd_pkg::out_item_t             q [wsd_pkg::RQ_DEPTH];
  logic [wsd_pkg::RQ_AW-1:0]      rd_ptr;
  logic [wsd_pkg::RQ_AW-1:0]      wr_ptr;
  logic                           rd;

  assign empty  = (count == '0);
  assign head   = q[rd_ptr];
  assign rd     = pop && !empty;
  assign wr_ptr = rd_ptr + count[wsd_pkg::RQ_AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/wsd_back.sv
`timescale 1ns / 1ps
module wsd_back #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  wsd_pkg::cmd_t           cmd,
  output logic                    empty,
  input  logic                    pop,
  output wsd_pkg::out_item_t      result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = CW + wsd_pkg::OCC_W;
  localparam int MW = (CW > wsd_pkg::LIMIT_W) ? CW : wsd_pkg::LIMIT_W;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_BATCH = 2'b10
  } state_t;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    return (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
  endfunction

  function automatic logic [wsd_pkg::OCC_W-1:0] to_occ(input logic [CW-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return e[wsd_pkg::OCC_W-1:0];
  endfunction

  logic [WORD_WIDTH-1:0]        ring [DEPTH];
  logic [WORD_WIDTH-1:0]        mem_q;

  state_t                       state, state_next;
  logic [AW-1:0]                top_slot, top_next;
  logic [AW-1:0]                bot_slot, bot_next;
  logic [CW-1:0]                count, count_next;
  logic [wsd_pkg::LIMIT_W-1:0]  batch_left, batch_left_next;

  logic                         mem_we, mem_re;
  logic [AW-1:0]                wr_addr, rd_addr;

  logic                         iss_valid, iss_last, iss_rd;
  logic [1:0]                   iss_status;
  logic [wsd_pkg::OCC_W-1:0]    iss_occ;

  logic                         p1_valid, p1_last, p1_rd;
  logic [1:0]                   p1_status;
  logic [wsd_pkg::OCC_W-1:0]    p1_occ;

  logic [wsd_pkg::RQ_AW:0]      rq_count;
  logic [wsd_pkg::RQ_AW:0]      rq_pending;
  logic                         can_issue;
  wsd_pkg::out_item_t           rq_in;

  logic                         is_full, is_empty;
  logic [MW-1:0]                lim_e, cnt_e;
  logic [wsd_pkg::LIMIT_W-1:0]  batch_n;

  // Hold one slot of the result queue per result in flight
  assign rq_pending = rq_count + {{wsd_pkg::RQ_AW{1'b0}}, p1_valid};
  assign can_issue  = (rq_pending < (wsd_pkg::RQ_AW + 1)'(wsd_pkg::RQ_DEPTH));

  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign lim_e    = MW'(cmd.limit);
  assign cnt_e    = MW'(count);
  assign batch_n  = (lim_e < cnt_e) ? cmd.limit : cnt_e[wsd_pkg::LIMIT_W-1:0];

  always_comb begin
    state_next      = state;
    top_next        = top_slot;
    bot_next        = bot_slot;
    count_next      = count;
    batch_left_next = batch_left;
    cmd_ready       = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    wr_addr         = bot_slot;
    rd_addr         = top_slot;
    iss_valid       = 1'b0;
    iss_status      = wsd_pkg::STATUS_OK;
    iss_last        = 1'b1;
    iss_occ         = '0;
    iss_rd          = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = can_issue;
        if (cmd_valid && can_issue) begin
          if (cmd.kind == wsd_pkg::CMD_PUSH) begin
            iss_valid = 1'b1;
            if (is_full) begin
              iss_status = wsd_pkg::STATUS_FULL;
              iss_occ    = to_occ(count);
            end else begin
              mem_we     = 1'b1;
              bot_next   = slot_inc(bot_slot);
              count_next = count + CW'(1);
              iss_occ    = to_occ(count + CW'(1));
            end
          end else if (is_empty) begin
            iss_valid  = 1'b1;
            iss_status = wsd_pkg::STATUS_EMPTY;
          end else begin
            case (cmd.kind)
              wsd_pkg::CMD_TAKE: begin
                iss_valid  = 1'b1;
                iss_rd     = 1'b1;
                mem_re     = 1'b1;
                rd_addr    = slot_dec(bot_slot);
                bot_next   = slot_dec(bot_slot);
                count_next = count - CW'(1);
                iss_occ    = to_occ(count - CW'(1));
              end
              wsd_pkg::CMD_STEAL: begin
                iss_valid  = 1'b1;
                iss_rd     = 1'b1;
                mem_re     = 1'b1;
                top_next   = slot_inc(top_slot);
                count_next = count - CW'(1);
                iss_occ    = to_occ(count - CW'(1));
              end
              default: begin
                batch_left_next = batch_n;
                state_next      = S_BATCH;
              end
            endcase
          end
        end
      end
      S_BATCH: begin
        // One word from the top per cycle while the result queue has room, oldest first
        if (can_issue) begin
          iss_valid       = 1'b1;
          iss_rd          = 1'b1;
          mem_re          = 1'b1;
          iss_last        = (batch_left == wsd_pkg::LIMIT_W'(1));
          top_next        = slot_inc(top_slot);
          count_next      = count - CW'(1);
          iss_occ         = to_occ(count - CW'(1));
          batch_left_next = batch_left - wsd_pkg::LIMIT_W'(1);
          if (batch_left == wsd_pkg::LIMIT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Ring storage: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wr_addr] <= cmd.word[WORD_WIDTH-1:0];
    end
    if (mem_re) begin
      mem_q <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    p1_status <= iss_status;
    p1_last   <= iss_last;
    p1_occ    <= iss_occ;
    p1_rd     <= iss_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      top_slot   <= '0;
      bot_slot   <= '0;
      count      <= '0;
      batch_left <= '0;
      p1_valid   <= 1'b0;
    end else begin
      state      <= state_next;
      top_slot   <= top_next;
      bot_slot   <= bot_next;
      count      <= count_next;
      batch_left <= batch_left_next;
      p1_valid   <= iss_valid;
    end
  end

  always_comb begin
    rq_in.status    = p1_status;
    rq_in.out_word  = p1_rd ? 64'(mem_q) : 64'd0;
    rq_in.last      = p1_last;
    rq_in.occupancy = p1_occ;
  end

  wsd_rq u_rq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (p1_valid),
    .wr_data (rq_in),
    .count   (rq_count),
    .empty   (empty),
    .pop     (pop),
    .head    (result)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above capacity");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");

  a_batch_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_BATCH) |-> (batch_left != '0) && (count != '0))
    else $error("batch running with nothing left");

  a_rq_room: assert property (@(posedge clk) disable iff (rst)
    rq_pending <= (wsd_pkg::RQ_AW + 1)'(wsd_pkg::RQ_DEPTH))
    else $error("result queue overcommitted");

endmodule
